[sv/pidf_pkg.sv]
// ----------------------------------------------------------------------------
// Packet ID duplicate filter package
// Shared types and constants for the run-list cells and the top level.
// ----------------------------------------------------------------------------
package pidf_pkg;

  localparam int unsigned IdW  = 16;
  localparam int unsigned LenW = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } pidf_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOW,
    OP_HIGH,
    OP_MERGE,
    OP_INSERT
  } pidf_op_e;

  typedef struct packed {
    pidf_op_e         op;
    logic [IdW-1:0]   id;
  } pidf_cmd_t;

  typedef struct packed {
    logic le;
    logic is_p;
    logic is_q;
    logic dup;
    logic lo;
    logic hi;
  } pidf_flags_t;

endpackage

[sv/pidf_cell.sv]
// ----------------------------------------------------------------------------
// Run-list cell
// Holds one run of seen identifiers, compares it against the request and
// loads from itself, a neighbor or the identifier in the update cycle.
// ----------------------------------------------------------------------------
module pidf_cell (
  input  logic                          clk_i,
  input  logic                          cmp_en_i,
  input  logic                          upd_en_i,
  input  pidf_pkg::pidf_cmd_t           cmd_i,
  input  logic                          valid_i,
  input  logic                          prev_le_i,
  input  logic                          next_le_i,
  input  logic                          prev_le_q_i,
  input  logic [pidf_pkg::IdW-1:0]      prev_start_i,
  input  logic [pidf_pkg::LenW-1:0]     prev_len_i,
  input  logic [pidf_pkg::IdW-1:0]      next_start_i,
  input  logic [pidf_pkg::LenW-1:0]     next_len_i,
  output logic                          le_o,
  output pidf_pkg::pidf_flags_t         flags_o,
  output logic [pidf_pkg::IdW-1:0]      start_o,
  output logic [pidf_pkg::LenW-1:0]     len_o
);

  logic [pidf_pkg::IdW-1:0]  start_q, start_d;
  logic [pidf_pkg::LenW-1:0] len_q, len_d;
  pidf_pkg::pidf_flags_t     flags_q, flags_d;
  logic [pidf_pkg::IdW:0]    run_end;
  logic [pidf_pkg::IdW:0]    id_ext;

  assign run_end = {1'b0, start_q} + {1'b0, len_q};
  assign id_ext  = {1'b0, cmd_i.id};
  assign le_o    = valid_i && (start_q <= cmd_i.id);

  always_comb begin
    flags_d.le   = le_o;
    flags_d.is_p = le_o && !next_le_i;
    flags_d.is_q = valid_i && !le_o && prev_le_i;
    flags_d.dup  = flags_d.is_p && (id_ext <= run_end);
    flags_d.lo   = flags_d.is_p && ((run_end + 17'd1) == id_ext);
    flags_d.hi   = flags_d.is_q && ({1'b0, start_q} == (id_ext + 17'd1));
  end

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    case (cmd_i.op)
      pidf_pkg::OP_LOW: begin
        if (flags_q.is_p) begin
          len_d = len_q + 16'd1;
        end
      end
      pidf_pkg::OP_HIGH: begin
        if (flags_q.is_q) begin
          start_d = cmd_i.id;
          len_d   = len_q + 16'd1;
        end
      end
      pidf_pkg::OP_MERGE: begin
        if (flags_q.is_p) begin
          len_d = len_q + next_len_i + 16'd2;
        end else if (!flags_q.le) begin
          start_d = next_start_i;
          len_d   = next_len_i;
        end
      end
      pidf_pkg::OP_INSERT: begin
        if (!flags_q.le) begin
          if (prev_le_q_i) begin
            start_d = cmd_i.id;
            len_d   = '0;
          end else begin
            start_d = prev_start_i;
            len_d   = prev_len_i;
          end
        end
      end
      default: begin
        start_d = start_q;
        len_d   = len_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      flags_q <= flags_d;
    end
    if (upd_en_i) begin
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

  assign flags_o = flags_q;
  assign start_o = start_q;
  assign len_o   = len_q;

endmodule

[sv/packet_id_duplicate_filter_top.sv]
// ----------------------------------------------------------------------------
// Packet ID duplicate filter
// Answers whether a packet identifier is new and records it in a sorted
// list of runs held in a row of cells, unless it needs a new run while all cells are in use.
// ----------------------------------------------------------------------------
// Each request passes a compare state, in which every cell compares its run
// against the identifier and registers its flags, and then an update state,
// in which each cell loads from itself, a neighbor or the identifier, which
// shifts the list for an insert or a merge. A new request is taken in the
// update state; the compare state waits while the previous result is undrained.
// The list is empty after reset, and no clearing pass is needed.
module packet_id_duplicate_filter_top #(
  parameter int unsigned MAX_RUNS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] packet_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_new_o,
  output logic        table_full_o
);

  localparam int unsigned CntW = $clog2(MAX_RUNS + 1);

  pidf_pkg::pidf_state_e    state_q, state_d;
  logic [pidf_pkg::IdW-1:0] id_q;
  logic [CntW-1:0]          count_q, count_d;
  logic                     out_valid_q;
  logic                     is_new_q, full_q;
  logic                     cmp_en, upd_en;
  pidf_pkg::pidf_cmd_t      cmd;

  logic                     valid_vec [MAX_RUNS];
  logic                     le_vec    [MAX_RUNS];
  pidf_pkg::pidf_flags_t    flags_vec [MAX_RUNS];
  logic [pidf_pkg::IdW-1:0]  start_vec [MAX_RUNS];
  logic [pidf_pkg::LenW-1:0] len_vec   [MAX_RUNS];
  logic [MAX_RUNS-1:0]      dup_vec, lo_vec, hi_vec, p_vec;

  logic any_dup, any_lo, any_hi, tbl_full;

  for (genvar k = 0; k < MAX_RUNS; k++) begin : g_cell
    logic                      prev_le, prev_le_q, next_le;
    logic [pidf_pkg::IdW-1:0]  prev_start, next_start;
    logic [pidf_pkg::LenW-1:0] prev_len, next_len;

    assign valid_vec[k] = (count_q > CntW'(k));

    if (k == 0) begin : g_first
      assign prev_le    = 1'b1;
      assign prev_le_q  = 1'b1;
      assign prev_start = '0;
      assign prev_len   = '0;
    end else begin : g_mid
      assign prev_le    = le_vec[k-1];
      assign prev_le_q  = flags_vec[k-1].le;
      assign prev_start = start_vec[k-1];
      assign prev_len   = len_vec[k-1];
    end

    if (k == MAX_RUNS - 1) begin : g_last
      assign next_le    = 1'b0;
      assign next_start = '0;
      assign next_len   = '0;
    end else begin : g_inner
      assign next_le    = le_vec[k+1];
      assign next_start = start_vec[k+1];
      assign next_len   = len_vec[k+1];
    end

    pidf_cell u_cell (
      .clk_i        (clk_i),
      .cmp_en_i     (cmp_en),
      .upd_en_i     (upd_en),
      .cmd_i        (cmd),
      .valid_i      (valid_vec[k]),
      .prev_le_i    (prev_le),
      .next_le_i    (next_le),
      .prev_le_q_i  (prev_le_q),
      .prev_start_i (prev_start),
      .prev_len_i   (prev_len),
      .next_start_i (next_start),
      .next_len_i   (next_len),
      .le_o         (le_vec[k]),
      .flags_o      (flags_vec[k]),
      .start_o      (start_vec[k]),
      .len_o        (len_vec[k])
    );

    assign dup_vec[k] = flags_vec[k].dup;
    assign lo_vec[k]  = flags_vec[k].lo;
    assign hi_vec[k]  = flags_vec[k].hi;
    assign p_vec[k]   = flags_vec[k].is_p;
  end

  assign any_dup  = |dup_vec;
  assign any_lo   = |lo_vec;
  assign any_hi   = |hi_vec;
  assign tbl_full = (count_q == CntW'(MAX_RUNS));

  always_comb begin
    cmd.id = id_q;
    if (any_dup) begin
      cmd.op = pidf_pkg::OP_NONE;
    end else if (any_lo && any_hi) begin
      cmd.op = pidf_pkg::OP_MERGE;
    end else if (any_lo) begin
      cmd.op = pidf_pkg::OP_LOW;
    end else if (any_hi) begin
      cmd.op = pidf_pkg::OP_HIGH;
    end else if (tbl_full) begin
      cmd.op = pidf_pkg::OP_NONE;
    end else begin
      cmd.op = pidf_pkg::OP_INSERT;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pidf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pidf_pkg::ST_CMP;
        end
      end
      pidf_pkg::ST_CMP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = pidf_pkg::ST_UPD;
        end
      end
      pidf_pkg::ST_UPD: begin
        if (in_valid_i) begin
          state_d = pidf_pkg::ST_CMP;
        end else begin
          state_d = pidf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pidf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmp_en     = 1'b0;
    upd_en     = 1'b0;
    case (state_q)
      pidf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      pidf_pkg::ST_CMP: begin
        cmp_en = 1'b1;
      end
      pidf_pkg::ST_UPD: begin
        in_ready_o = 1'b1;
        upd_en     = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (upd_en) begin
      case (cmd.op)
        pidf_pkg::OP_MERGE:  count_d = count_q - CntW'(1);
        pidf_pkg::OP_INSERT: count_d = count_q + CntW'(1);
        default:             count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidf_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (upd_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      id_q <= packet_id_i;
    end
    if (upd_en) begin
      is_new_q <= !any_dup;
      full_q   <= !any_dup && !any_lo && !any_hi && tbl_full;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_new_o     = is_new_q;
  assign table_full_o = full_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RUNS))
    else $error("run count exceeds the number of cells");

  a_one_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_en |-> $onehot0(p_vec))
    else $error("more than one cell claims the run below the identifier");

  a_upd_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_en |-> !out_valid_q)
    else $error("update cycle entered while the result register is occupied");

  a_full_on_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(upd_en) && table_full_o |-> is_new_o && $past(tbl_full))
    else $error("full flag raised without a full table or on a duplicate");

endmodule
